// ===== hw/rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants for the sliding window maximum block
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int SWM_MAX_WINDOW  = 16;
	localparam int SWM_SAMPLE_BITS = 32;
	localparam int SWM_LEN_BITS    = 5;
	localparam logic [SWM_LEN_BITS-1:0] SWM_LEN_RESET = 5'd5;

endpackage

// ===== hw/rtl/swm_if.sv =====
// ----------------------------------------------------------------------------
// swm_sample_if / swm_result_if
// valid/ready channels for input samples and window maximum results
// ----------------------------------------------------------------------------
interface swm_sample_if #(
	parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          first_of_sequence;

	modport source (output valid, output sample, output first_of_sequence, input ready);
	modport sink   (input valid, input sample, input first_of_sequence, output ready);
endinterface

interface swm_result_if #(
	parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] window_max;

	modport source (output valid, output window_max, input ready);
	modport sink   (input valid, input window_max, output ready);
endinterface

// ===== hw/rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// one cell of the running maximum chain: holds the maximum of the last k+1
// samples and builds its next value from its neighbor and the new sample
// ----------------------------------------------------------------------------
module swm_cell #(
	parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic signed [SAMPLE_BITS-1:0] neighbor,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0] next_max,
	output logic signed [SAMPLE_BITS-1:0] cur_max
);

	logic signed [SAMPLE_BITS-1:0] max_q;

	assign next_max = (neighbor > sample) ? neighbor : sample;
	assign cur_max  = max_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			max_q <= next_max;
		end
	end

endmodule

// ===== hw/rtl/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl
// window length register, sequence fill count and result decision
// ----------------------------------------------------------------------------
module swm_ctrl #(
	parameter int MAX_WINDOW = swm_pkg::SWM_MAX_WINDOW,
	localparam int FILL_W = $clog2(MAX_WINDOW + 1),
	localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [swm_pkg::SWM_LEN_BITS-1:0] cfg_write_data,
	input  logic                            xfer,
	input  logic                            first,
	output logic                            emit,
	output logic [IDX_W-1:0]                sel
);

	localparam int CMP_W = (FILL_W > swm_pkg::SWM_LEN_BITS) ? FILL_W : swm_pkg::SWM_LEN_BITS;

	logic [swm_pkg::SWM_LEN_BITS-1:0] len_q;
	logic [FILL_W-1:0]                fill_q;
	logic [FILL_W-1:0]                fill_next;
	logic [CMP_W-1:0]                 len_w;
	logic [CMP_W-1:0]                 used_len;
	logic [CMP_W-1:0]                 last_idx;

	assign len_w = CMP_W'(len_q);

	always_comb begin
		if (len_w == '0) begin
			used_len = CMP_W'(1);
		end else if (len_w > CMP_W'(MAX_WINDOW)) begin
			used_len = CMP_W'(MAX_WINDOW);
		end else begin
			used_len = len_w;
		end
	end

	always_comb begin
		if (first) begin
			fill_next = FILL_W'(1);
		end else if (fill_q == FILL_W'(MAX_WINDOW)) begin
			fill_next = fill_q;
		end else begin
			fill_next = fill_q + FILL_W'(1);
		end
	end

	assign last_idx = used_len - CMP_W'(1);
	assign sel      = last_idx[IDX_W-1:0];
	assign emit     = CMP_W'(fill_next) >= used_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= swm_pkg::SWM_LEN_RESET;
			fill_q <= '0;
		end else begin
			if (cfg_write_en) begin
				len_q <= cfg_write_data;
			end
			if (xfer) begin
				fill_q <= fill_next;
			end
		end
	end

endmodule

// ===== hw/rtl/sliding_window_maximum.sv =====
// a result is in the output register in the cycle after its sample transfer
// throughput: one sample per cycle while the input is not stalled, set by the single compare in each chain cell
// the input stalls only while a finished result waits and the output is not ready
// reset: fill count and output valid cleared, window length back to 5
// chain contents are not reset; a result never reads a cell that holds stale samples
// ----------------------------------------------------------------------------
// sliding_window_maximum
// running maximum over the last window_length samples, built as a chain of
// cells where cell k holds the maximum of the last k+1 samples
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
	parameter int MAX_WINDOW  = swm_pkg::SWM_MAX_WINDOW,
	parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [swm_pkg::SWM_LEN_BITS-1:0] cfg_write_data,
	swm_sample_if.sink                       samples,
	swm_result_if.source                     results
);

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	logic                          xfer;
	logic                          emit;
	logic [IDX_W-1:0]              sel;
	logic signed [SAMPLE_BITS-1:0] next_max [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] cur_max  [MAX_WINDOW];
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	assign samples.ready = !out_valid_q || results.ready;
	assign xfer          = samples.valid && samples.ready;

	swm_ctrl #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.xfer          (xfer),
		.first         (samples.first_of_sequence),
		.emit          (emit),
		.sel           (sel)
	);

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		if (k == 0) begin : g_head
			swm_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk     (clk),
				.shift_en(xfer),
				.neighbor(samples.sample),
				.sample  (samples.sample),
				.next_max(next_max[k]),
				.cur_max (cur_max[k])
			);
		end else begin : g_body
			swm_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk     (clk),
				.shift_en(xfer),
				.neighbor(cur_max[k-1]),
				.sample  (samples.sample),
				.next_max(next_max[k]),
				.cur_max (cur_max[k])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer && emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && emit) begin
			out_data_q <= next_max[sel];
		end
	end

	assign results.valid      = out_valid_q;
	assign results.window_max = out_data_q;

endmodule

// ===== hw/rtl/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker
// port level checks on the sliding window maximum block
// ----------------------------------------------------------------------------
module swm_checker #(
	parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// a new result only follows an input transfer
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without input transfer");

	// empty output slot never blocks input
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// drained output with no new transfer leaves the slot empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
		else $error("result repeated");

endmodule

bind sliding_window_maximum swm_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_swm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_data (results.window_max)
);

// ===== tb/sv/window_max_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_max_checker
// watches the sample, result and window length ports of the block, keeps its
// own ring of recent samples and fill count, and checks each window maximum
// against the oldest one it has worked out
// ----------------------------------------------------------------------------
module window_max_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [swm_pkg::SWM_LEN_BITS-1:0] cfg_write_data,
	swm_sample_if                            samples,
	swm_result_if                            results,
	output int                               errors,
	output int                               pending,
	output int                               samples_seen,
	output int                               maxima_checked
);

	typedef logic signed [swm_pkg::SWM_SAMPLE_BITS-1:0] sample_t;

	sample_t                          ring [swm_pkg::SWM_MAX_WINDOW];
	sample_t                          expected_max [$];
	int                               head;
	int                               filled;
	logic [swm_pkg::SWM_LEN_BITS-1:0] span_setting;

	function automatic int active_span(input logic [swm_pkg::SWM_LEN_BITS-1:0] setting);
		if (setting == 0)
			return 1;
		if (setting > swm_pkg::SWM_MAX_WINDOW)
			return swm_pkg::SWM_MAX_WINDOW;
		return int'(setting);
	endfunction

	task automatic flag(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic take_sample(input sample_t value, input logic restart);
		int      span;
		int      slot;
		int      n;
		int      idx;
		sample_t peak;
		span = active_span(span_setting);
		if (restart)
			filled = 0;
		ring[head] = value;
		slot = head;
		head = (head + 1) % swm_pkg::SWM_MAX_WINDOW;
		if (filled < swm_pkg::SWM_MAX_WINDOW)
			filled++;
		samples_seen++;
		if (filled >= span) begin
			peak = value;
			for (n = 1; n < span; n++) begin
				idx = (slot + swm_pkg::SWM_MAX_WINDOW - n) % swm_pkg::SWM_MAX_WINDOW;
				if (ring[idx] > peak)
					peak = ring[idx];
			end
			expected_max = {expected_max, peak};
		end
	endtask

	task automatic check_max(input sample_t got);
		sample_t want;
		if (expected_max.size() == 0) begin
			flag($sformatf("window max %0d with none expected", got));
		end else begin
			want = expected_max.pop_front();
			maxima_checked++;
			if (got !== want)
				flag($sformatf("window max mismatch: expected %0d, got %0d", want, got));
		end
	endtask

	// result transfers first, then the sample, then the length write
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_max.delete();
			head = 0;
			filled = 0;
			span_setting = swm_pkg::SWM_LEN_RESET;
		end else begin
			if (results.valid && results.ready)
				check_max(results.window_max);
			if (samples.valid && samples.ready)
				take_sample(samples.sample, samples.first_of_sequence);
			if (cfg_write_en)
				span_setting = cfg_write_data;
		end
		pending = expected_max.size();
	end

endmodule

// ===== tb/sv/sliding_window_maximum_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_maximum_tb
// drives sample sequences through the sliding window maximum block under
// several window lengths, with bursty input, a stalling output and one long
// output hold-off; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module sliding_window_maximum_tb;

	typedef logic signed [swm_pkg::SWM_SAMPLE_BITS-1:0] sample_t;
	typedef logic [swm_pkg::SWM_LEN_BITS-1:0] len_t;

	localparam sample_t MOST_NEGATIVE = {1'b1, {(swm_pkg::SWM_SAMPLE_BITS-1){1'b0}}};
	localparam sample_t MOST_POSITIVE = {1'b0, {(swm_pkg::SWM_SAMPLE_BITS-1){1'b1}}};
	localparam int      PHASE_COUNT    = 14;
	localparam int      SQUEEZE_PHASE  = 11;
	localparam int      HOLD_CYCLES    = 150;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write_en;
	len_t cfg_write_data;

	swm_sample_if samples ();
	swm_result_if results ();

	int errors;
	int pending;
	int samples_seen;
	int maxima_checked;
	int burst_left = 0;
	int window_writes = 0;
	bit hold_request = 1'b0;

	always #2 clk = ~clk;

	sliding_window_maximum dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.samples        (samples),
		.results        (results)
	);

	window_max_checker max_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.samples        (samples),
		.results        (results),
		.errors         (errors),
		.pending        (pending),
		.samples_seen   (samples_seen),
		.maxima_checked (maxima_checked)
	);

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return MOST_NEGATIVE;
			1: return MOST_POSITIVE;
			2, 3: return $signed(32'($urandom_range(0, 16))) - 8;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(input sample_t value, input logic restart);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				samples.valid <= 1'b0;
				samples.sample <= $urandom;
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		samples.valid <= 1'b1;
		samples.sample <= value;
		samples.first_of_sequence <= restart;
		do @(posedge clk); while (!samples.ready);
		burst_left--;
	endtask

	task automatic settle();
		@(negedge clk);
		samples.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_window(input len_t setting);
		settle();
		cfg_write_en <= 1'b1;
		cfg_write_data <= setting;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		window_writes++;
	endtask

	task automatic run_phase(input len_t setting, input int items, input bit squeeze);
		int      sent;
		int      run_len;
		int      trend;
		int      k;
		bit      carry_on;
		sample_t value;
		set_window(setting);
		if (squeeze) begin
			hold_request = 1'b1;
			burst_left = 80;
		end
		// sometimes keep the previous sequence going under the new length
		carry_on = ($urandom_range(0, 2) == 0);
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 9) == 0)
				run_len = $urandom_range(1, 4);
			else
				run_len = $urandom_range(swm_pkg::SWM_MAX_WINDOW,
					swm_pkg::SWM_MAX_WINDOW + 30);
			trend = $urandom_range(0, 3);
			value = pick_sample();
			for (k = 0; k < run_len && sent < items; k++) begin
				if (k > 0) begin
					case (trend)
						1: value = value + sample_t'($urandom_range(0, 500));
						2: value = value - sample_t'($urandom_range(0, 500));
						default: value = pick_sample();
					endcase
				end
				send_sample(value, (k == 0 && !(sent == 0 && carry_on)) ||
					($urandom_range(0, 60) == 0));
				sent++;
			end
		end
	endtask

	// output side: own stall pattern, plus one long hold-off on request
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		results.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				results.ready <= 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (mode)
					0: results.ready <= 1'b1;
					1: results.ready <= $urandom_range(0, 1);
					default: results.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		#2000000;
		$display("sliding_window_maximum_tb NOT OK");
		$finish;
	end

	initial begin
		len_t plan [PHASE_COUNT];
		int   p;
		plan = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd2, 5'd17, 5'd3, 5'd5, 5'd8, 5'd15, 5'd4,
			5'd1, 5'd16, 5'd31};
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		samples.valid = 1'b0;
		samples.sample = '0;
		samples.first_of_sequence = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// window length still at its reset value
		send_sample(MOST_NEGATIVE, 1'b1);
		send_sample(MOST_POSITIVE, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(0, 1'b0);
		send_sample(1, 1'b0);
		repeat (6) send_sample(MOST_NEGATIVE, 1'b0);
		// restart mid-stream, then shorten the window mid-sequence
		send_sample(7, 1'b1);
		send_sample(-7, 1'b0);
		send_sample(3, 1'b0);
		set_window(5'd2);
		send_sample(-2, 1'b0);
		// zero length acts as one
		set_window(5'd0);
		send_sample(-5, 1'b0);
		send_sample(MOST_POSITIVE, 1'b1);
		send_sample(MOST_NEGATIVE, 1'b0);

		for (p = 0; p < PHASE_COUNT; p++)
			run_phase(plan[p], 30, p == SQUEEZE_PHASE);

		settle();
		repeat (8) @(negedge clk);
		$display("run covered %0d samples and %0d window maxima over %0d window length writes",
			samples_seen, maxima_checked, window_writes);
		$display("lengths included zero, one, sixteen and above sixteen, plus one long output stall");
		if (errors == 0)
			$display("sliding_window_maximum_tb OK");
		else
			$display("sliding_window_maximum_tb NOT OK");
		$finish;
	end

endmodule

// ===== sliding_window_maximum.f =====
hw/rtl/swm_pkg.sv
hw/rtl/swm_if.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_ctrl.sv
hw/rtl/sliding_window_maximum.sv
hw/rtl/swm_checker.sv
tb/sv/window_max_checker.sv
tb/sv/sliding_window_maximum_tb.sv
